### rtl/hcbp_pkg.sv
// Shared types, field widths and codes for the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

    // Field widths of the input and result items.
    localparam int ACT_W     = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_FLD_W = 6;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;

    // Bit positions and sizes used by the packer.
    localparam int CODE_TOP  = 31;
    localparam int BYTE_TOP  = 7;
    localparam int BYTE_BITS = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_SYMBOL_COUNT  = 256;
    localparam int DEF_MAX_CODE_BITS = 32;

    // Action codes carried by an input item.
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    // Table write request.
    typedef struct packed {
        logic                 wr_en;
        logic [SYM_W-1:0]     addr;
        logic [CODE_W-1:0]    word;
        logic [LEN_FLD_W-1:0] len;
    } t_tbl_wr;

    // Table read data, with unloaded entries already forced to zero length.
    typedef struct packed {
        logic [CODE_W-1:0]    word;
        logic [LEN_FLD_W-1:0] len;
    } t_tbl_rd;

endpackage

`default_nettype wire

### rtl/huffman_code_bit_packer.sv
// Huffman code bit packer: code table, bit-serial shifter and byte output register.
// Load: a table write, no result. Encode: accept, then the registered table read,
// then the bit shifter sends the code bits one at a time into the byte accumulator.
// Finish: a padded byte. A stalled output register holding a byte pauses the shifter
// once the pending byte is full, until the held byte is transferred.
// Synchronous active-low reset clears the sequencer, accumulator and valid bits.
`default_nettype none

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT  = hcbp_pkg::DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_BITS = hcbp_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [hcbp_pkg::ACT_W-1:0]     i_action,
    input  logic [hcbp_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    i_code_word,
    input  logic [hcbp_pkg::LEN_FLD_W-1:0] i_code_length,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]    o_packed_byte,
    output logic                           o_run_last,
    output logic                           o_stream_end
);
    import hcbp_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    t_state r_state, n_state;

    logic [MAX_CODE_BITS-1:0] r_shift, n_shift;
    logic [LEN_W-1:0]         r_remain, n_remain;
    logic [BYTE_W-1:0]        r_pending, n_pending;
    logic [POS_W-1:0]         r_pos, n_pos;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_end, n_out_end;

    logic    in_xfer;
    logic    in_range;
    logic    out_free;
    logic    byte_full;
    logic    bit_step;
    logic    code_bit;
    t_action action;
    t_tbl_wr tbl_wr;
    t_tbl_rd tbl_rd;

    assign action    = t_action'(i_action);
    assign o_stall   = (r_state != ST_IDLE);
    assign in_xfer   = i_valid && !o_stall;
    assign in_range  = ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign out_free  = !r_out_valid || !i_stall;
    assign byte_full = (r_pos == POS_W'(BYTE_BITS));
    assign code_bit  = r_shift[MAX_CODE_BITS-1];
    assign bit_step  = (r_state == ST_SHIFT) && (!byte_full || out_free);

    // Table write on a load transfer, with the length saturated.
    always_comb begin
        tbl_wr.wr_en = in_xfer && (action == ACT_LOAD) && in_range;
        tbl_wr.addr  = i_symbol;
        tbl_wr.word  = i_code_word;
        if (i_code_length > LEN_FLD_W'(MAX_CODE_BITS)) begin
            tbl_wr.len = LEN_FLD_W'(MAX_CODE_BITS);
        end else begin
            tbl_wr.len = i_code_length;
        end
    end

    hcbp_table #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_symbol),
        .o_rd      (tbl_rd)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (action)
                        ACT_ENCODE: if (in_range) n_state = ST_READ;
                        ACT_FINISH: n_state = ST_FINISH;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (tbl_rd.len != '0) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (bit_step && (r_remain == LEN_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Shifter, accumulator and output register updates.
    always_comb begin
        n_shift     = r_shift;
        n_remain    = r_remain;
        n_pending   = r_pending;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_READ: begin
                n_shift  = tbl_rd.word[CODE_W-1 -: MAX_CODE_BITS];
                n_remain = LEN_W'(tbl_rd.len);
            end
            ST_SHIFT: begin
                if (bit_step) begin
                    n_shift  = r_shift << 1;
                    n_remain = r_remain - LEN_W'(1);
                    if (byte_full) begin
                        // The full byte leaves only now that another bit has come.
                        n_out_valid = 1'b1;
                        n_out_byte  = r_pending;
                        n_out_last  = (r_remain <= LEN_W'(BYTE_BITS));
                        n_out_end   = 1'b0;
                        n_pending   = {code_bit, {(BYTE_W - 1){1'b0}}};
                        n_pos       = POS_W'(1);
                    end else begin
                        n_pending = r_pending
                                  | (BYTE_W'(code_bit) << (3'(BYTE_TOP) - r_pos[2:0]));
                        n_pos     = r_pos + POS_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_pending;
                    n_out_last  = 1'b1;
                    n_out_end   = 1'b1;
                    n_pending   = '0;
                    n_pos       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_remain   <= n_remain;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_run_last    = r_out_last;
    assign o_stream_end  = r_out_end;

endmodule

`default_nettype wire

### rtl/hcbp_table.sv
// Code table memory with per-entry valid bits and a registered read port.
`default_nettype none

module hcbp_table #(
    parameter int SYMBOL_COUNT  = hcbp_pkg::DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_BITS = hcbp_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hcbp_pkg::t_tbl_wr          i_wr,
    input  logic                       i_rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0] i_rd_addr,
    output hcbp_pkg::t_tbl_rd          o_rd
);
    import hcbp_pkg::*;

    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);

    logic [MAX_CODE_BITS-1:0] r_word_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]         r_len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  r_valid;

    logic [MAX_CODE_BITS-1:0] r_rd_word;
    logic [LEN_W-1:0]         r_rd_len;
    logic                     r_rd_hit;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = i_wr.addr[ADDR_W-1:0];
    assign rd_addr = i_rd_addr[ADDR_W-1:0];

    // Valid bits: reset marks every entry as unloaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Entry storage; only the top code bits that can ever be sent are kept.
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_word_mem[wr_addr] <= i_wr.word[CODE_W-1 -: MAX_CODE_BITS];
            r_len_mem[wr_addr]  <= LEN_W'(i_wr.len);
        end
    end

    // Registered read of the entry and its valid bit.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_word_mem[rd_addr];
            r_rd_len  <= r_len_mem[rd_addr];
            r_rd_hit  <= r_valid[rd_addr];
        end
    end

    // Left-align the word again; an unloaded entry reads as length zero.
    assign o_rd.word = CODE_W'(r_rd_word) << (CODE_W - MAX_CODE_BITS);
    assign o_rd.len  = r_rd_hit ? LEN_FLD_W'(r_rd_len) : '0;

endmodule

`default_nettype wire

### rtl/hcbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
`default_nettype none

module hcbp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [hcbp_pkg::ACT_W-1:0]     i_action,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [hcbp_pkg::BYTE_W-1:0]    o_packed_byte,
    input logic                           o_run_last,
    input logic                           o_stream_end
);
    import hcbp_pkg::*;

    // The stream-end byte is always the last byte of its item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_end) |-> o_run_last)
        else $error("stream end byte without run_last");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_packed_byte)
                                  && $stable(o_run_last) && $stable(o_stream_end)))
        else $error("stalled result changed");

    // A finish transfer always occupies the block for the padded byte.
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_action == ACT_FINISH)) |=> o_stall)
        else $error("finish did not hold off the next transfer");

    // The block is ready for input right after reset.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_stall && !o_valid))
        else $error("not idle after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

`default_nettype wire
